// ----- hdl/bh_pkg.sv -----
// Shared types and constants for the byte histogram.
package bh_pkg;

	localparam int NUM_BINS         = 256;
	localparam int BIN_W            = 8;
	localparam int BYTE_W           = 8;
	localparam int WORD_W           = 64;
	localparam int NVALID_W         = 4;
	localparam int OUT_W            = 32;
	localparam int DEF_LANES        = 8;
	localparam int DEF_COUNT_BITS   = 32;

	typedef enum logic [1:0] {
		OP_COUNT    = 2'd0,
		OP_READ     = 2'd1,
		OP_READ_CLR = 2'd2
	} bh_op_t;

	typedef enum logic [1:0] {
		K_INC,
		K_READ,
		K_READ_CLR,
		K_CLEAR
	} bh_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_DRAIN
	} bh_state_t;

	typedef struct packed {
		bh_op_t                opcode;
		logic [WORD_W-1:0]     data_word;
		logic [NVALID_W-1:0]   valid_bytes;
		logic [BIN_W-1:0]      bin_index;
	} bh_cmd_t;

	typedef struct packed {
		logic [BIN_W-1:0]  read_bin;
		logic [OUT_W-1:0]  bin_count;
	} bh_result_t;

	typedef struct packed {
		logic              vld;
		bh_kind_t          kind;
		logic [BIN_W-1:0]  addr;
	} bh_issue_t;

endpackage

// ----- hdl/bh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/bh_seq.sv -----
// Sequencer: clearing sweep, item acceptance and per-byte memory read issue.
module bh_seq #(
	parameter int LANES = bh_pkg::DEF_LANES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bh_pkg::bh_cmd_t   cmd,
	output logic              busy,
	output bh_pkg::bh_issue_t issue
);
	import bh_pkg::*;

	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

	bh_state_t            state_q, state_d;
	logic [WORD_W-1:0]    word_q;
	logic [LANE_W-1:0]    lane_q;
	logic [LANE_W-1:0]    last_lane_q;
	logic [BIN_W-1:0]     clr_addr_q;
	logic                 accept;
	logic                 load_count;
	logic [NVALID_W-1:0]  n_clamp;

	assign accept  = start && !busy;
	assign n_clamp = (cmd.valid_bytes > NVALID_W'(LANES)) ? NVALID_W'(LANES) : cmd.valid_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			lane_q      <= '0;
			last_lane_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + BIN_W'(1);
			end
			if (load_count) begin
				lane_q      <= '0;
				last_lane_q <= LANE_W'(n_clamp - NVALID_W'(1));
			end else if (state_q == ST_COUNT) begin
				lane_q <= lane_q + LANE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_count) begin
			word_q <= cmd.data_word;
		end
	end

	always_comb begin
		state_d    = state_q;
		busy       = (state_q != ST_IDLE);
		load_count = 1'b0;
		issue.vld  = 1'b0;
		issue.kind = K_INC;
		issue.addr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				issue.vld  = 1'b1;
				issue.kind = K_CLEAR;
				issue.addr = clr_addr_q;
				if (clr_addr_q == BIN_W'(NUM_BINS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.opcode)
						OP_COUNT: begin
							if (n_clamp != '0) begin
								load_count = 1'b1;
								state_d    = ST_COUNT;
							end
						end
						OP_READ: begin
							issue.vld  = 1'b1;
							issue.kind = K_READ;
							issue.addr = cmd.bin_index;
							state_d    = ST_DRAIN;
						end
						OP_READ_CLR: begin
							issue.vld  = 1'b1;
							issue.kind = K_READ_CLR;
							issue.addr = cmd.bin_index;
							state_d    = ST_DRAIN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_COUNT: begin
				issue.vld  = 1'b1;
				issue.kind = K_INC;
				issue.addr = word_q[lane_q*BYTE_W +: BYTE_W];
				if (lane_q == last_lane_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/bh_rmw.sv -----
// Read-modify-write stage: forwarding, saturating increment, clear and read-out.
module bh_rmw #(
	parameter int COUNT_BITS = bh_pkg::DEF_COUNT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bh_pkg::bh_issue_t           issue,
	input  logic [COUNT_BITS-1:0]       rdata,
	output logic                        we,
	output logic [bh_pkg::BIN_W-1:0]    waddr,
	output logic [COUNT_BITS-1:0]       wdata,
	output logic                        strobe,
	output bh_pkg::bh_result_t          result
);
	import bh_pkg::*;

	localparam int EXT_W = OUT_W + COUNT_BITS;

	logic                   vld_s1;
	bh_kind_t               kind_s1;
	logic [BIN_W-1:0]       addr_s1;
	logic                   fwd_vld_q;
	logic [BIN_W-1:0]       fwd_addr_q;
	logic [COUNT_BITS-1:0]  fwd_data_q;
	logic [COUNT_BITS-1:0]  cur;
	logic [EXT_W-1:0]       ext;
	logic                   over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			vld_s1    <= issue.vld;
			fwd_vld_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1    <= issue.kind;
		addr_s1    <= issue.addr;
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
	end

	assign cur  = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata;
	assign ext  = EXT_W'(cur);
	assign over = |ext[EXT_W-1:OUT_W];

	always_comb begin
		we               = 1'b0;
		waddr            = addr_s1;
		wdata            = '0;
		strobe           = 1'b0;
		result.read_bin  = addr_s1;
		result.bin_count = over ? '1 : ext[OUT_W-1:0];
		unique case (kind_s1)
			K_INC: begin
				we    = vld_s1;
				wdata = (&cur) ? cur : cur + COUNT_BITS'(1);
			end
			K_READ: begin
				strobe = vld_s1;
			end
			K_READ_CLR: begin
				strobe = vld_s1;
				we     = vld_s1;
			end
			K_CLEAR: begin
				we = vld_s1;
			end
		endcase
	end

endmodule

// ----- hdl/byte_histogram.sv -----
// Top level of the 256-bin byte frequency histogram.
// An item is taken when start is high and busy is low. A count item holds the block busy
// while its n bytes are counted, n being the number of bytes counted (valid_bytes, at most
// LANES); one bin read-modify-write per byte through the single read and write port pair
// of the count memory sets this. A count item with no bytes, or an unused opcode, leaves busy
// low. A read or read-and-clear item also holds busy; its result is on result for the single
// cycle after the item is taken, marked by strobe, and must be captured then. After reset
// busy stays high while every bin is cleared.
module byte_histogram #(
	parameter int LANES      = bh_pkg::DEF_LANES,
	parameter int COUNT_BITS = bh_pkg::DEF_COUNT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bh_pkg::bh_cmd_t    cmd,
	output logic               strobe,
	output bh_pkg::bh_result_t result
);
	import bh_pkg::*;

	bh_issue_t              issue;
	logic                   we;
	logic [BIN_W-1:0]       waddr;
	logic [COUNT_BITS-1:0]  wdata;
	logic [COUNT_BITS-1:0]  rdata;

	bh_seq #(
		.LANES(LANES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.issue  (issue)
	);

	bh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BINS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue.vld),
		.raddr (issue.addr),
		.rdata (rdata)
	);

	bh_rmw #(
		.COUNT_BITS(COUNT_BITS)
	) u_rmw (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.rdata  (rdata),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.strobe (strobe),
		.result (result)
	);

	a_strobe_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy &&
			(cmd.opcode == OP_READ || cmd.opcode == OP_READ_CLR)))
		else $error("result without a read item");

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.opcode == OP_READ || cmd.opcode == OP_READ_CLR))
		|=> (strobe && result.read_bin == $past(cmd.bin_index)))
		else $error("read item gave no result or wrong bin");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result while idle");

endmodule

// ----- sim/tb_byte_histogram.sv -----
// Self-checking testbench for the 256-bin byte histogram: directed rows, then random items.
module tb_byte_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	import bh_pkg::*;

	localparam int LANES      = DEF_LANES;
	localparam int COUNT_BITS = DEF_COUNT_BITS;
	localparam int RAND_ITEMS = 1500;
	localparam int MAX_GAP    = 12;
	localparam int DRAIN      = 16;
	localparam int STALL_LIMIT = 4000;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	typedef struct {
		bh_cmd_t         item;
		bit              known;
		logic [OUT_W-1:0] want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	bh_cmd_t     cmd;
	logic        strobe;
	bh_result_t  result;

	logic             row_known;
	logic [OUT_W-1:0] row_want;

	logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
	bh_result_t            owed_counts [$];
	dir_row_t              dir_tab [$];
	logic [BYTE_W-1:0]     byte_pool [8];

	int errors;
	int stall_cycles;
	int n_count, n_read, n_clear, n_spare, n_bytes, n_results;

	byte_histogram #(
		.LANES(LANES),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic flag_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic bh_cmd_t make_item(logic [1:0] op, logic [WORD_W-1:0] word,
			logic [NVALID_W-1:0] nv, logic [BIN_W-1:0] bin);
		bh_cmd_t c;
		c.opcode      = bh_op_t'(op);
		c.data_word   = word;
		c.valid_bytes = nv;
		c.bin_index   = bin;
		return c;
	endfunction

	function automatic void add_row(logic [1:0] op, logic [WORD_W-1:0] word,
			logic [NVALID_W-1:0] nv, logic [BIN_W-1:0] bin, bit known,
			logic [OUT_W-1:0] want);
		dir_row_t r;
		r.item  = make_item(op, word, nv, bin);
		r.known = known;
		r.want  = want;
		dir_tab.push_back(r);
	endfunction

	// Update the bins for one taken item and queue the count it owes, if any.
	function automatic void tally_item(bh_cmd_t c, bit known, logic [OUT_W-1:0] want);
		int nv;
		logic [BYTE_W-1:0] b;
		logic [63:0] v;
		bh_result_t r;
		case (c.opcode)
			OP_COUNT: begin
				n_count++;
				nv = (int'(c.valid_bytes) > LANES) ? LANES : int'(c.valid_bytes);
				for (int k = 0; k < nv; k++) begin
					b = c.data_word[BYTE_W*k +: BYTE_W];
					if (hist_bins[b] != '1)
						hist_bins[b]++;
					n_bytes++;
				end
			end
			OP_READ, OP_READ_CLR: begin
				v = 64'(hist_bins[c.bin_index]);
				r.read_bin  = c.bin_index;
				r.bin_count = (v > 64'hFFFF_FFFF) ? '1 : v[OUT_W-1:0];
				if (known)
					r.bin_count = want;
				owed_counts.push_back(r);
				if (c.opcode == OP_READ_CLR) begin
					hist_bins[c.bin_index] = '0;
					n_clear++;
				end else begin
					n_read++;
				end
			end
			default: n_spare++;
		endcase
	endfunction

	function automatic bh_cmd_t random_item();
		int pick;
		logic [1:0] op;
		logic [WORD_W-1:0] word;
		logic [NVALID_W-1:0] nv;
		logic [BIN_W-1:0] bin;
		pick = $urandom_range(0, 99);
		op = (pick < 55) ? OP_COUNT : (pick < 80) ? OP_READ :
			(pick < 95) ? OP_READ_CLR : OP_SPARE;
		word = {$urandom, $urandom};
		if ($urandom_range(0, 1))
			for (int k = 0; k < 8; k++)
				word[BYTE_W*k +: BYTE_W] = byte_pool[3'($urandom_range(0, 7))];
		nv = ($urandom_range(0, 99) < 85) ? NVALID_W'($urandom_range(0, 8)) :
			NVALID_W'($urandom_range(9, 15));
		bin = ($urandom_range(0, 99) < 60) ? byte_pool[3'($urandom_range(0, 7))] :
			BIN_W'($urandom);
		return make_item(op, word, nv, bin);
	endfunction

	task automatic issue_item(input bh_cmd_t c, input bit known, input logic [OUT_W-1:0] want,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		cmd       <= c;
		row_known <= known;
		row_want  <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	always @(posedge clk) begin
		bh_result_t w;
		bit took;
		if (arst_n) begin
			took = (start === 1'b1) && (busy === 1'b0);
			if (strobe === 1'b1) begin
				if (owed_counts.size() == 0) begin
					flag_mismatch($sformatf("result for bin %0d with nothing owed",
						result.read_bin));
				end else begin
					w = owed_counts.pop_front();
					n_results++;
					if (result.read_bin !== w.read_bin)
						flag_mismatch($sformatf("read_bin %0d, want %0d",
							result.read_bin, w.read_bin));
					if (result.bin_count !== w.bin_count)
						flag_mismatch($sformatf("bin %0d count %0d, want %0d",
							w.read_bin, result.bin_count, w.bin_count));
				end
			end
			if (took)
				tally_item(cmd, row_known, row_want);
			if (took || strobe === 1'b1) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("timeout: no item taken for %0d cycles", STALL_LIMIT);
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	initial begin
		bit burst;
		int gap;
		for (int i = 0; i < NUM_BINS; i++)
			hist_bins[i] = '0;
		for (int i = 0; i < 8; i++)
			byte_pool[i] = BYTE_W'($urandom);
		byte_pool[0] = 8'h00;
		byte_pool[1] = 8'hFF;
		errors = 0;
		stall_cycles = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		row_known = 1'b0;
		row_want  = '0;

		add_row(OP_READ,     '0, 4'd0, 8'd0,   1, 32'd0);
		add_row(OP_READ,     '0, 4'd0, 8'd255, 1, 32'd0);
		add_row(OP_READ_CLR, '0, 4'd0, 8'd128, 1, 32'd0);
		add_row(OP_COUNT,    ALL_ONES, 4'd0, 8'd255, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'd255, 1, 32'd0);
		add_row(OP_COUNT,    ALL_ONES, 4'd8, 8'd0, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'd255, 1, 32'd8);
		add_row(OP_COUNT,    64'h0706_0504_0302_0100, 4'd15, 8'd0, 0, '0);
		add_row(OP_COUNT,    64'h0706_0504_0302_0100, 4'd9, 8'd0, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'd7, 0, '0);
		add_row(OP_COUNT,    '0, 4'd8, 8'hAA, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'd0, 0, '0);
		add_row(OP_SPARE,    ALL_ONES, 4'd8, 8'd0, 0, '0);
		add_row(OP_READ,     ALL_ONES, 4'd15, 8'd0, 0, '0);
		add_row(OP_READ_CLR, ALL_ONES, 4'd8, 8'd0, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'd0, 1, 32'd0);
		add_row(OP_COUNT,    64'hAA55_AA55_AA55_AA55, 4'd5, 8'd0, 0, '0);
		add_row(OP_COUNT,    64'h55AA_55AA_55AA_55AA, 4'd1, 8'd0, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'hAA, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'h55, 0, '0);
		add_row(OP_READ_CLR, '0, 4'd0, 8'd255, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'd255, 1, 32'd0);
		add_row(OP_COUNT,    64'h8040_2010_0804_0201, 4'd8, 8'd0, 0, '0);
		add_row(OP_READ,     '0, 4'd0, 8'h80, 0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			issue_item(dir_tab[i].item, dir_tab[i].known, dir_tab[i].want,
				$urandom_range(0, 3));

		burst = 1'b0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (i % 200 == 199)
				byte_pool[3'($urandom_range(2, 7))] = BYTE_W'($urandom);
			gap = burst ? 0 : $urandom_range(0, MAX_GAP);
			issue_item(random_item(), 1'b0, '0, gap);
		end
		start <= 1'b0;

		while (owed_counts.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d count items (%0d bytes), %0d reads, %0d read-and-clears,",
			n_count, n_bytes, n_read, n_clear);
		$display("%0d unused-opcode items; %0d counts checked, %0d mismatches",
			n_spare, n_results, errors);
		if (errors == 0 && owed_counts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/bh_pkg.sv
hdl/bh_ram.sv
hdl/bh_seq.sv
hdl/bh_rmw.sv
hdl/byte_histogram.sv
sim/tb_byte_histogram.sv
